[src/bb3_pkg.sv]
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur
// Frame limits, pixel and window types, register indexes and the constant
// divide by nine.
// ----------------------------------------------------------------------------
package bb3_pkg;

  // Frame limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Widths
  localparam int COL_W   = $clog2(MAX_WIDTH);        // column index
  localparam int DIM_W   = 11;                       // frame size registers
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);   // input line, runs to height + 1
  localparam int CH_W    = 8;
  localparam int SUM_W   = 12;                       // nine 8-bit values
  localparam int POS_W   = 10;                       // col / row of a result
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] MAX_WIDTH_D  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_HEIGHT_D = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd800;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd600;
  localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hFF;

  // ceil(2^16 / 9): exact floor quotient for sums below 2^12
  localparam logic [12:0] RECIP9 = 13'd7282;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // One line store entry: two lines above the current one at a column
  typedef struct packed {
    pix_t upper;
    pix_t lower;
  } line_pair_t;

  // One window column, top line first
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } wcol_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic first;   // column zero: drop the old left columns
  } win_ctrl_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sums_t;

  // Clamp a written frame size into 1 .. limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] limit);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > limit) begin
      r = limit;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Truncating divide by nine through the reciprocal
  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] x);
    logic [24:0] p;
    p = {13'd0, x} * {12'd0, RECIP9};
    return p[23:16];
  endfunction

endpackage

[src/box_blur_3x3_stream_core.sv]
// Results pass stage 1, stage 2 and the output register after the causing item
//   is accepted; that item is one line plus one pixel after the blurred pixel.
// Throughput: one item per cycle while the output register is not stalled.
// Reset: synchronous; frame size goes to 800 x 600, positions and window to
//   zero. Line store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_core: streaming 3x3 box blur over RGB frames
// Input stage with line store read, window and sum stage, then divide into
// the output register. A frame of W x H takes W*H pixel items plus W+1
// drain items.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream_core (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration
  input  logic                              cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bb3_pkg::DIM_W-1:0]         cfg_data,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,  // in_red, in_green, in_blue
  input  logic                              s_axis_tuser,  // drain
  // Output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_red, out_green, out_blue, out_alpha, out_col, out_row, 4 zero bits
  output logic [55:0]                       m_axis_tdata,
  output logic                              m_axis_tlast   // frame_done
);

  // Frame size registers
  logic [bb3_pkg::DIM_W-1:0] frame_width;
  logic [bb3_pkg::DIM_W-1:0] frame_height;

  // Input position counters
  logic [bb3_pkg::COL_W-1:0] in_col;
  logic [bb3_pkg::ROW_W-1:0] in_row;

  // Stage 1
  logic                      s1_valid;
  bb3_pkg::pix_t             s1_pix;
  logic [bb3_pkg::COL_W-1:0] s1_col;
  logic [bb3_pkg::ROW_W-1:0] s1_row;
  logic                      fwd;
  bb3_pkg::line_pair_t       fwd_data;
  bb3_pkg::line_pair_t       rd_data;

  // Stage 2
  logic                      s2_valid;
  bb3_pkg::sums_t            s2_sums;
  logic [bb3_pkg::POS_W-1:0] s2_col;
  logic [bb3_pkg::POS_W-1:0] s2_row;
  logic                      s2_done;

  logic                      adv;
  logic                      accept;
  logic                      s1_go;
  logic                      cfg_restart;
  logic                      in_wrap;
  logic [bb3_pkg::DIM_W-1:0] col_inc;
  bb3_pkg::pix_t             in_pix;
  bb3_pkg::line_pair_t       lines;
  bb3_pkg::line_pair_t       wr_data;
  bb3_pkg::wcol_t            new_col;
  bb3_pkg::win_ctrl_t        win_ctrl;
  bb3_pkg::sums_t            sums;
  logic                      s1_emit;
  logic [bb3_pkg::DIM_W-1:0] ocol;
  logic [bb3_pkg::ROW_W-1:0] orow;
  logic                      odone;

  // Whole pipeline moves when the output register is free
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign s1_go         = s1_valid && adv;

  // Configuration writes; any write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::WIDTH_RESET;
      frame_height <= bb3_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bb3_pkg::CFG_FRAME_WIDTH:
          frame_width  <= bb3_pkg::clamp_dim(cfg_data, bb3_pkg::MAX_WIDTH_D);
        bb3_pkg::CFG_FRAME_HEIGHT:
          frame_height <= bb3_pkg::clamp_dim(cfg_data, bb3_pkg::MAX_HEIGHT_D);
        default: ;
      endcase
    end
  end

  assign cfg_restart = cfg_we && (cfg_index == bb3_pkg::CFG_FRAME_WIDTH ||
                                  cfg_index == bb3_pkg::CFG_FRAME_HEIGHT);

  // Input position; the last drain item of a frame sits at (height + 1, 0)
  assign col_inc = bb3_pkg::DIM_W'(in_col) + bb3_pkg::DIM_W'(1);
  assign in_wrap = (in_col == '0) &&
                   (in_row == bb3_pkg::ROW_W'(frame_height) + bb3_pkg::ROW_W'(1));

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      in_col <= '0;
      in_row <= '0;
    end else if (accept) begin
      if (in_wrap) begin
        in_col <= '0;
        in_row <= '0;
      end else if (col_inc >= frame_width) begin
        in_col <= '0;
        in_row <= in_row + bb3_pkg::ROW_W'(1);
      end else begin
        in_col <= col_inc[bb3_pkg::COL_W-1:0];
      end
    end
  end

  // Drain items and lines below the frame count as black
  always_comb begin
    in_pix = '0;
    if (!s_axis_tuser && (bb3_pkg::DIM_W'(in_row) < frame_height)) begin
      in_pix.red   = s_axis_tdata[7:0];
      in_pix.green = s_axis_tdata[15:8];
      in_pix.blue  = s_axis_tdata[23:16];
    end
  end

  // Stage 1 capture, with bypass when stage 1 writes the column being read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= in_pix;
      s1_col   <= in_col;
      s1_row   <= in_row;
      fwd      <= s1_go && (s1_col == in_col);
      fwd_data <= wr_data;
    end
  end

  bb3_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_col),
    .rd_data (rd_data),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  // Window column from the two stored lines and the new pixel
  always_comb begin
    lines         = fwd ? fwd_data : rd_data;
    wr_data.upper = lines.lower;
    wr_data.lower = s1_pix;
    new_col.top   = (s1_row >= bb3_pkg::ROW_W'(2)) ? lines.upper : '0;
    new_col.mid   = (s1_row != '0) ? lines.lower : '0;
    new_col.bot   = s1_pix;
    win_ctrl.clear = cfg_restart;
    win_ctrl.shift = s1_go;
    win_ctrl.first = (s1_col == '0);
  end

  bb3_window u_window (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (win_ctrl),
    .col_in (new_col),
    .sums   (sums)
  );

  // Position of the blurred pixel, one line and one pixel back
  always_comb begin
    s1_emit = (s1_row >= bb3_pkg::ROW_W'(2)) ||
              (s1_row == bb3_pkg::ROW_W'(1) && s1_col != '0);
    if (s1_col != '0) begin
      ocol = bb3_pkg::DIM_W'(s1_col) - bb3_pkg::DIM_W'(1);
      orow = s1_row - bb3_pkg::ROW_W'(1);
    end else begin
      ocol = frame_width - bb3_pkg::DIM_W'(1);
      orow = s1_row - bb3_pkg::ROW_W'(2);
    end
    odone = (orow == bb3_pkg::ROW_W'(frame_height - bb3_pkg::DIM_W'(1))) &&
            (ocol == frame_width - bb3_pkg::DIM_W'(1));
  end

  // Stage 2: sums and position
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sums <= sums;
      s2_col  <= ocol[bb3_pkg::POS_W-1:0];
      s2_row  <= orow[bb3_pkg::POS_W-1:0];
      s2_done <= odone;
    end
  end

  // Output register: divide by nine and pack
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {4'd0, s2_row, s2_col, bb3_pkg::ALPHA_OPAQUE,
                       bb3_pkg::div9(s2_sums.blue), bb3_pkg::div9(s2_sums.green),
                       bb3_pkg::div9(s2_sums.red)};
      m_axis_tlast <= s2_done;
    end
  end

  // Input column stays inside the frame
  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    bb3_pkg::DIM_W'(in_col) < frame_width)
    else $error("input column beyond frame width");

  // Input line never runs past the last drain line
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    in_row <= bb3_pkg::ROW_W'(frame_height) + bb3_pkg::ROW_W'(1))
    else $error("input line beyond drain line");

  // The first line of a frame produces no result
  a_no_emit_top: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_row == '0) |=> !s2_valid)
    else $error("result from first input line");

  // Frame end marks the bottom right pixel
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tdata[41:32] == bb3_pkg::POS_W'(frame_width - bb3_pkg::DIM_W'(1)) &&
       m_axis_tdata[51:42] == bb3_pkg::POS_W'(frame_height - bb3_pkg::DIM_W'(1))))
    else $error("frame end away from last pixel");

endmodule

[src/bb3_line_ram.sv]
// ----------------------------------------------------------------------------
// bb3_line_ram: line store of the box blur
// One entry per column holding the two previous lines; one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module bb3_line_ram (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [bb3_pkg::COL_W-1:0]     rd_addr,
  output bb3_pkg::line_pair_t           rd_data,
  input  logic                          wr_en,
  input  logic [bb3_pkg::COL_W-1:0]     wr_addr,
  input  bb3_pkg::line_pair_t           wr_data
);

  bb3_pkg::line_pair_t mem [bb3_pkg::MAX_WIDTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/bb3_window.sv]
// ----------------------------------------------------------------------------
// bb3_window: 3x3 window and neighbourhood sums
// Holds the two older window columns and sums them with the incoming column
// per channel.
// ----------------------------------------------------------------------------
module bb3_window (
  input  logic               clk,
  input  logic               rst,
  input  bb3_pkg::win_ctrl_t ctrl,
  input  bb3_pkg::wcol_t     col_in,
  output bb3_pkg::sums_t     sums
);

  // Left column first, then the middle one; the oldest column is never read again
  bb3_pkg::wcol_t win [2];

  // Sum one window column per channel
  function automatic bb3_pkg::sums_t col_sum(input bb3_pkg::wcol_t c);
    bb3_pkg::sums_t s;
    s.red   = bb3_pkg::SUM_W'(c.top.red)   + bb3_pkg::SUM_W'(c.mid.red)
            + bb3_pkg::SUM_W'(c.bot.red);
    s.green = bb3_pkg::SUM_W'(c.top.green) + bb3_pkg::SUM_W'(c.mid.green)
            + bb3_pkg::SUM_W'(c.bot.green);
    s.blue  = bb3_pkg::SUM_W'(c.top.blue)  + bb3_pkg::SUM_W'(c.mid.blue)
            + bb3_pkg::SUM_W'(c.bot.blue);
    return s;
  endfunction

  bb3_pkg::sums_t s1;
  bb3_pkg::sums_t s2;
  bb3_pkg::sums_t s3;

  // Old left and middle columns, plus the new right column unless it starts a line
  always_comb begin
    s1 = col_sum(win[0]);
    s2 = col_sum(win[1]);
    s3 = ctrl.first ? '0 : col_sum(col_in);
    sums.red   = s1.red   + s2.red   + s3.red;
    sums.green = s1.green + s2.green + s3.green;
    sums.blue  = s1.blue  + s2.blue  + s3.blue;
  end

  // Shift the window, or restart it at the first column of a line
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      win[0] <= '0;
      win[1] <= '0;
    end else if (ctrl.shift) begin
      if (ctrl.first) begin
        win[0] <= '0;
      end else begin
        win[0] <= win[1];
      end
      win[1] <= col_in;
    end
  end

endmodule
